@@ src/v3mu_pkg.sv @@
// ----------------------------------------------------------------------------
// v3mu_pkg
// Shared widths, opcodes and request/response types for the vector math unit.
// ----------------------------------------------------------------------------
`default_nettype none

package v3mu_pkg;

    localparam int CW  = 32;
    localparam int FB  = 16;
    localparam int OW  = CW + 1;
    localparam int PW  = 2 * OW;
    localparam int SQW = 2 * OW;
    localparam int RW  = OW;
    localparam int WW  = PW + 2;
    localparam int DVW = CW + FB;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_DOT   = 4'd4,
        OP_CROSS = 4'd5,
        OP_MAG   = 4'd6,
        OP_DIST  = 4'd7,
        OP_NORM  = 4'd8,
        OP_SDIV  = 4'd9,
        OP_CMP   = 4'd10
    } t_op;

    typedef logic signed [CW-1:0] t_comp;

    typedef struct packed {
        logic [3:0] opcode;
        t_comp      a_x;
        t_comp      a_y;
        t_comp      a_z;
        t_comp      b_x;
        t_comp      b_y;
        t_comp      b_z;
    } t_req;

    typedef struct packed {
        t_comp r_x;
        t_comp r_y;
        t_comp r_z;
        t_comp r_scalar;
        logic  vec_equal;
        logic  mag_less;
        logic  mag_equal;
        logic  saturated;
    } t_rsp;

    typedef struct packed {
        logic [3:0] op;
        t_comp      a_s;
        t_comp      b_s;
        t_comp      a_n;
        t_comp      b_n;
        t_comp      a_nn;
        t_comp      b_nn;
    } t_lane_in;

    typedef struct packed {
        logic [3:0]  op;
        t_comp [2:0] a;
        t_comp [2:0] b;
        t_comp [2:0] r;
        t_comp       s;
        logic        eq;
        logic        lt;
        logic        me;
        logic        sat;
        logic        mzero;
    } t_side;

endpackage

`default_nettype wire

@@ src/v3mu_lane.sv @@
// ----------------------------------------------------------------------------
// v3mu_lane
// One component lane: picks operands for the opcode and forms two products.
// ----------------------------------------------------------------------------
`default_nettype none

module v3mu_lane (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  v3mu_pkg::t_lane_in                  i_lane,
    output logic signed [v3mu_pkg::PW-1:0]      o_p1,
    output logic signed [v3mu_pkg::PW-1:0]      o_p2
);

    logic signed [v3mu_pkg::OW-1:0] a_s, b_s, a_n, b_n, a_nn, b_nn, d_s;
    logic signed [v3mu_pkg::OW-1:0] x1, y1, x2, y2;
    logic signed [v3mu_pkg::PW-1:0] r_p1, r_p2;

    always_comb begin
        a_s  = {i_lane.a_s[v3mu_pkg::CW-1], i_lane.a_s};
        b_s  = {i_lane.b_s[v3mu_pkg::CW-1], i_lane.b_s};
        a_n  = {i_lane.a_n[v3mu_pkg::CW-1], i_lane.a_n};
        b_n  = {i_lane.b_n[v3mu_pkg::CW-1], i_lane.b_n};
        a_nn = {i_lane.a_nn[v3mu_pkg::CW-1], i_lane.a_nn};
        b_nn = {i_lane.b_nn[v3mu_pkg::CW-1], i_lane.b_nn};
        d_s  = a_s - b_s;
        x1 = '0;
        y1 = '0;
        x2 = '0;
        y2 = '0;
        case (i_lane.op)
            v3mu_pkg::OP_MUL, v3mu_pkg::OP_DOT: begin
                x1 = a_s;
                y1 = b_s;
            end
            v3mu_pkg::OP_CROSS: begin
                x1 = a_n;
                y1 = b_nn;
                x2 = b_n;
                y2 = a_nn;
            end
            v3mu_pkg::OP_MAG, v3mu_pkg::OP_NORM: begin
                x1 = a_s;
                y1 = a_s;
            end
            v3mu_pkg::OP_DIST: begin
                x1 = d_s;
                y1 = d_s;
            end
            v3mu_pkg::OP_CMP: begin
                x1 = a_s;
                y1 = a_s;
                x2 = b_s;
                y2 = b_s;
            end
            default: begin
                x1 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= x1 * y1;
            r_p2 <= x2 * y2;
        end
    end

    assign o_p1 = r_p1;
    assign o_p2 = r_p2;

endmodule

`default_nettype wire

@@ src/v3mu_isqrt.sv @@
// ----------------------------------------------------------------------------
// v3mu_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v3mu_isqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [v3mu_pkg::SQW-1:0]      i_rad,
    output logic [v3mu_pkg::RW-1:0]       o_root
);

    localparam int RW  = v3mu_pkg::RW;
    localparam int SQW = v3mu_pkg::SQW;
    localparam int RMW = RW + 3;

    logic [RMW-1:0] r_rem  [RW];
    logic [RW-1:0]  r_root [RW];
    logic [SQW-1:0] r_rad  [RW];
    logic [RMW-1:0] n_rem  [RW];
    logic [RW-1:0]  n_root [RW];
    logic [SQW-1:0] n_rad  [RW];
    logic [RMW-1:0] s_rem  [RW];
    logic [RW-1:0]  s_root [RW];
    logic [SQW-1:0] s_rad  [RW];
    logic [RMW-1:0] sh     [RW];
    logic [RMW-1:0] trial  [RW];

    always_comb begin
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_rad[0]  = i_rad;
        for (int i = 1; i < RW; i++) begin
            s_rem[i]  = r_rem[i-1];
            s_root[i] = r_root[i-1];
            s_rad[i]  = r_rad[i-1];
        end
        for (int i = 0; i < RW; i++) begin
            sh[i]    = {s_rem[i][RMW-3:0], s_rad[i][SQW-1 -: 2]};
            trial[i] = {1'b0, s_root[i], 2'b01};
            if (sh[i] >= trial[i]) begin
                n_rem[i]  = sh[i] - trial[i];
                n_root[i] = {s_root[i][RW-2:0], 1'b1};
            end else begin
                n_rem[i]  = sh[i];
                n_root[i] = {s_root[i][RW-2:0], 1'b0};
            end
            n_rad[i] = {s_rad[i][SQW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < RW; i++) begin
                r_rem[i]  <= n_rem[i];
                r_root[i] <= n_root[i];
                r_rad[i]  <= n_rad[i];
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

`default_nettype wire

@@ src/v3mu_div.sv @@
// ----------------------------------------------------------------------------
// v3mu_div
// Pipelined unsigned divider for (num << FB) / den, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v3mu_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [v3mu_pkg::CW-1:0]       i_num,
    input  logic [v3mu_pkg::CW-1:0]       i_den,
    output logic [v3mu_pkg::DVW-1:0]      o_quo
);

    localparam int CW  = v3mu_pkg::CW;
    localparam int DVW = v3mu_pkg::DVW;
    localparam int RMW = CW + 1;

    logic [RMW-1:0] r_rem [DVW];
    logic [DVW-1:0] r_quo [DVW];
    logic [DVW-1:0] r_num [DVW];
    logic [CW-1:0]  r_den [DVW];
    logic [RMW-1:0] n_rem [DVW];
    logic [DVW-1:0] n_quo [DVW];
    logic [DVW-1:0] n_num [DVW];
    logic [RMW-1:0] s_rem [DVW];
    logic [DVW-1:0] s_quo [DVW];
    logic [DVW-1:0] s_num [DVW];
    logic [CW-1:0]  s_den [DVW];
    logic [RMW-1:0] sh    [DVW];

    always_comb begin
        s_rem[0] = '0;
        s_quo[0] = '0;
        s_num[0] = {i_num, {v3mu_pkg::FB{1'b0}}};
        s_den[0] = i_den;
        for (int i = 1; i < DVW; i++) begin
            s_rem[i] = r_rem[i-1];
            s_quo[i] = r_quo[i-1];
            s_num[i] = r_num[i-1];
            s_den[i] = r_den[i-1];
        end
        for (int i = 0; i < DVW; i++) begin
            sh[i] = {s_rem[i][RMW-2:0], s_num[i][DVW-1]};
            if (sh[i] >= {1'b0, s_den[i]}) begin
                n_rem[i] = sh[i] - {1'b0, s_den[i]};
                n_quo[i] = {s_quo[i][DVW-2:0], 1'b1};
            end else begin
                n_rem[i] = sh[i];
                n_quo[i] = {s_quo[i][DVW-2:0], 1'b0};
            end
            n_num[i] = {s_num[i][DVW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < DVW; i++) begin
                r_rem[i] <= n_rem[i];
                r_quo[i] <= n_quo[i];
                r_num[i] <= n_num[i];
                r_den[i] <= s_den[i];
            end
        end
    end

    assign o_quo = r_quo[DVW-1];

endmodule

`default_nettype wire

@@ src/vec3_math_unit_core.sv @@
// ----------------------------------------------------------------------------
// vec3_math_unit_core
// Three-component Q16.16 vector ALU: add, sub, mul, div, dot, cross,
// magnitude, distance, normalize, scalar divide and compare.
// ----------------------------------------------------------------------------
// request channel: i_req_valid / o_req_stall carry opcode and vectors a, b
// response channel: o_rsp_valid / i_rsp_stall carry the result vector,
// scalar, compare bits and the saturation flag
// every request gives exactly one response, in request order
// a taken request passes through the input register, multiply lanes, sum,
// reduce, 33-stage root pipeline, 48-stage divider lanes and output
// register before its response is valid
// one request per cycle unless stalled; every opcode takes the same path
// while the response register holds a stalled result the whole pipeline
// freezes and o_req_stall is raised; it drops in the cycle the result leaves
// reset clears all stage valid bits; no response is pending after reset
// ----------------------------------------------------------------------------
`default_nettype none

module vec3_math_unit_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  v3mu_pkg::t_req    i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    output v3mu_pkg::t_rsp    o_rsp
);

    localparam int CW  = v3mu_pkg::CW;
    localparam int FB  = v3mu_pkg::FB;
    localparam int PW  = v3mu_pkg::PW;
    localparam int SQW = v3mu_pkg::SQW;
    localparam int RW  = v3mu_pkg::RW;
    localparam int WW  = v3mu_pkg::WW;
    localparam int DVW = v3mu_pkg::DVW;

    localparam logic signed [WW-1:0] W_MAX = {{(WW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [WW-1:0] W_MIN = {{(WW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic signed [WW-1:0] W_RND = {{(WW-FB){1'b0}}, {FB{1'b1}}};
    localparam logic [CW-1:0]        C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]        C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [RW-1:0]        R_MAX = {2'b00, {(CW-1){1'b1}}};

    function automatic logic signed [WW-1:0] tshift(input logic signed [WW-1:0] x);
        logic signed [WW-1:0] t;
        t = x[WW-1] ? (x + W_RND) : x;
        return t >>> FB;
    endfunction

    function automatic logic [CW:0] sat_w(input logic signed [WW-1:0] x);
        logic [CW:0] t;
        if (x > W_MAX) begin
            t = {1'b1, C_MAX};
        end else if (x < W_MIN) begin
            t = {1'b1, C_MIN};
        end else begin
            t = {1'b0, x[CW-1:0]};
        end
        return t;
    endfunction

    function automatic logic [CW-1:0] uabs(input v3mu_pkg::t_comp v);
        logic [CW-1:0] t;
        t = v[CW-1] ? CW'(-v) : v;
        return t;
    endfunction

    logic en;

    // stage 0: input register
    logic                  r_v0;
    v3mu_pkg::t_req        r_req0;
    v3mu_pkg::t_comp [2:0] a0, b0;
    v3mu_pkg::t_lane_in    lane_in [3];
    logic signed [PW-1:0]  p1 [3];
    logic signed [PW-1:0]  p2 [3];

    // stage 1 to 3
    logic                  r_v1, r_v2, r_v3;
    v3mu_pkg::t_side       r_side1, r_side2, r_side3;
    v3mu_pkg::t_side       n_side1, n_side3;
    logic signed [WW-1:0]  r_wide [3];
    logic signed [WW-1:0]  n_wide [3];
    logic signed [WW-1:0]  r_dot, n_dot;
    logic [SQW-1:0]        r_sqa, r_sqb, n_sqa, n_sqb;
    logic [SQW-1:0]        r_sq3;
    logic [CW:0]           st3 [3];
    logic [CW:0]           st_dot;

    // root and divider pipelines
    logic                  r_vs [RW];
    v3mu_pkg::t_side       r_ss [RW];
    logic [RW-1:0]         root;
    v3mu_pkg::t_side       n_sd0;
    logic [CW-1:0]         div_num [3];
    logic [CW-1:0]         div_den [3];
    logic [DVW-1:0]        quo [3];
    logic                  r_vd [DVW];
    v3mu_pkg::t_side       r_sd [DVW];

    // output
    logic                  r_rsp_valid;
    v3mu_pkg::t_rsp        r_rsp, n_rsp;
    v3mu_pkg::t_side       fs;
    logic signed [WW-1:0]  qv [3];
    logic [CW:0]           qs [3];
    v3mu_pkg::t_comp [2:0] fr;
    logic                  fflag;
    logic                  neg;

    assign en          = !r_rsp_valid || !i_rsp_stall;
    assign o_req_stall = !en;

    always_comb begin
        a0[0] = r_req0.a_x;
        a0[1] = r_req0.a_y;
        a0[2] = r_req0.a_z;
        b0[0] = r_req0.b_x;
        b0[1] = r_req0.b_y;
        b0[2] = r_req0.b_z;
        n_side1     = '0;
        n_side1.op  = r_req0.opcode;
        n_side1.a   = a0;
        n_side1.b   = b0;
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        always_comb begin
            lane_in[g].op   = r_req0.opcode;
            lane_in[g].a_s  = a0[g];
            lane_in[g].b_s  = b0[g];
            lane_in[g].a_n  = a0[(g + 1) % 3];
            lane_in[g].b_n  = b0[(g + 1) % 3];
            lane_in[g].a_nn = a0[(g + 2) % 3];
            lane_in[g].b_nn = b0[(g + 2) % 3];
        end

        v3mu_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (lane_in[g]),
            .o_p1   (p1[g]),
            .o_p2   (p2[g])
        );

        v3mu_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (div_num[g]),
            .i_den (div_den[g]),
            .o_quo (quo[g])
        );
    end

    // stage 2: lane merge and wide sums
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (r_side1.op)
                v3mu_pkg::OP_ADD: begin
                    n_wide[i] = WW'(r_side1.a[i]) + WW'(r_side1.b[i]);
                end
                v3mu_pkg::OP_SUB: begin
                    n_wide[i] = WW'(r_side1.a[i]) - WW'(r_side1.b[i]);
                end
                v3mu_pkg::OP_MUL: begin
                    n_wide[i] = WW'(p1[i]);
                end
                v3mu_pkg::OP_CROSS: begin
                    n_wide[i] = WW'(p1[i]) - WW'(p2[i]);
                end
                default: begin
                    n_wide[i] = '0;
                end
            endcase
        end
        n_dot = WW'(p1[0]) + WW'(p1[1]) + WW'(p1[2]);
        n_sqa = p1[0][SQW-1:0] + p1[1][SQW-1:0] + p1[2][SQW-1:0];
        n_sqb = p2[0][SQW-1:0] + p2[1][SQW-1:0] + p2[2][SQW-1:0];
    end

    // stage 3: rounding, saturation and compare
    always_comb begin
        n_side3 = r_side2;
        for (int i = 0; i < 3; i++) begin
            if (r_side2.op inside {v3mu_pkg::OP_MUL, v3mu_pkg::OP_CROSS}) begin
                st3[i] = sat_w(tshift(r_wide[i]));
            end else begin
                st3[i] = sat_w(r_wide[i]);
            end
            n_side3.r[i] = st3[i][CW-1:0];
        end
        st_dot = sat_w(tshift(r_dot));
        n_side3.sat = st3[0][CW] | st3[1][CW] | st3[2][CW];
        if (r_side2.op == v3mu_pkg::OP_DOT) begin
            n_side3.s   = st_dot[CW-1:0];
            n_side3.sat = st_dot[CW];
        end
        if (r_side2.op == v3mu_pkg::OP_CMP) begin
            n_side3.eq = (r_side2.a == r_side2.b);
            n_side3.me = (r_sqa == r_sqb);
            n_side3.lt = (r_sqa < r_sqb);
        end
    end

    v3mu_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_sq3),
        .o_root (root)
    );

    // after the root: magnitude result and divider operands
    always_comb begin
        n_sd0       = r_ss[RW-1];
        n_sd0.mzero = (root == '0);
        if (r_ss[RW-1].op inside {v3mu_pkg::OP_MAG, v3mu_pkg::OP_DIST}) begin
            if (root > R_MAX) begin
                n_sd0.s   = C_MAX;
                n_sd0.sat = 1'b1;
            end else begin
                n_sd0.s = root[CW-1:0];
            end
        end
        for (int i = 0; i < 3; i++) begin
            div_num[i] = uabs(r_ss[RW-1].a[i]);
            case (r_ss[RW-1].op)
                v3mu_pkg::OP_DIV:  div_den[i] = uabs(r_ss[RW-1].b[i]);
                v3mu_pkg::OP_SDIV: div_den[i] = uabs(r_ss[RW-1].b[0]);
                v3mu_pkg::OP_NORM: div_den[i] = root[CW-1:0];
                default:           div_den[i] = '0;
            endcase
        end
    end

    // final merge of quotients with the carried results
    always_comb begin
        fs    = r_sd[DVW-1];
        fr    = fs.r;
        fflag = fs.sat;
        neg   = 1'b0;
        for (int i = 0; i < 3; i++) begin
            neg   = fs.a[i][CW-1] ^ ((fs.op == v3mu_pkg::OP_DIV) && fs.b[i][CW-1]);
            qv[i] = neg ? -WW'(quo[i]) : WW'(quo[i]);
            qs[i] = sat_w(qv[i]);
            case (fs.op)
                v3mu_pkg::OP_DIV: begin
                    if (fs.b != '0) begin
                        if (fs.b[i] != '0) begin
                            fr[i] = qs[i][CW-1:0];
                            fflag = fflag | qs[i][CW];
                        end else if (fs.a[i][CW-1]) begin
                            fr[i] = C_MIN;
                            fflag = 1'b1;
                        end else if (fs.a[i] != '0) begin
                            fr[i] = C_MAX;
                            fflag = 1'b1;
                        end
                    end
                end
                v3mu_pkg::OP_NORM: begin
                    if (!fs.mzero) begin
                        fr[i] = qs[i][CW-1:0];
                        fflag = fflag | qs[i][CW];
                    end
                end
                v3mu_pkg::OP_SDIV: begin
                    if (!fs.b[0][CW-1] && (fs.b[0] != '0)) begin
                        fr[i] = qs[i][CW-1:0];
                        fflag = fflag | qs[i][CW];
                    end
                end
                default: begin
                    fr[i] = fs.r[i];
                end
            endcase
        end
        n_rsp.r_x       = fr[0];
        n_rsp.r_y       = fr[1];
        n_rsp.r_z       = fr[2];
        n_rsp.r_scalar  = fs.s;
        n_rsp.vec_equal = fs.eq;
        n_rsp.mag_less  = fs.lt;
        n_rsp.mag_equal = fs.me;
        n_rsp.saturated = fflag;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_req0  <= i_req;
            r_side1 <= n_side1;
            r_side2 <= r_side1;
            r_wide  <= n_wide;
            r_dot   <= n_dot;
            r_sqa   <= n_sqa;
            r_sqb   <= n_sqb;
            r_side3 <= n_side3;
            r_sq3   <= r_sqa;
            r_ss[0] <= r_side3;
            for (int i = 1; i < RW; i++) begin
                r_ss[i] <= r_ss[i-1];
            end
            r_sd[0] <= n_sd0;
            for (int i = 1; i < DVW; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
            r_rsp <= n_rsp;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_rsp_valid <= 1'b0;
            for (int i = 0; i < RW; i++) begin
                r_vs[i] <= 1'b0;
            end
            for (int i = 0; i < DVW; i++) begin
                r_vd[i] <= 1'b0;
            end
        end else if (en) begin
            r_v0    <= i_req_valid;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_vs[0] <= r_v3;
            for (int i = 1; i < RW; i++) begin
                r_vs[i] <= r_vs[i-1];
            end
            r_vd[0] <= r_vs[RW-1];
            for (int i = 1; i < DVW; i++) begin
                r_vd[i] <= r_vd[i-1];
            end
            r_rsp_valid <= r_vd[DVW-1];
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_order_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.mag_less && o_rsp.mag_equal))
        else $error("mag_less and mag_equal both set");

    a_equal_vectors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.vec_equal) |-> o_rsp.mag_equal)
        else $error("equal vectors without equal magnitude");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_stall && !r_vd[DVW-1]) |=> !o_rsp_valid)
        else $error("response repeated after it was taken");

endmodule

`default_nettype wire

@@ tb/sv/vec3_math_unit_core_tb.sv @@
// ----------------------------------------------------------------------------
// vec3_math_unit_core_tb
// Self-checking bench for the Q16.16 vector ALU. Directed corner requests,
// then random requests with random gaps and response stalls, including one
// long response hold-off. Every response is checked field by field against
// an in-bench predictor of the exact fixed-point results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vec3_math_unit_core_tb;

    typedef logic signed [129:0] t_wide;

    localparam logic [3:0] OP_UNUSED = 4'd15;
    localparam t_wide SMAX = (t_wide'(1) <<< (v3mu_pkg::CW - 1)) - 1;
    localparam t_wide SMIN = -(t_wide'(1) <<< (v3mu_pkg::CW - 1));

    logic            i_clk;
    logic            i_rst_n;
    logic            i_req_valid;
    logic            o_req_stall;
    v3mu_pkg::t_req  i_req;
    logic            o_rsp_valid;
    logic            i_rsp_stall;
    v3mu_pkg::t_rsp  o_rsp;

    v3mu_pkg::t_req  pending_reqs[$];
    v3mu_pkg::t_rsp  expected_rsps[$];
    int    gap_cnt;
    int    hold_cnt;
    int    long_cnt;
    bit    long_done;
    int    rsp_count;
    int    req_count;
    bit    failed;

    vec3_math_unit_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    function automatic v3mu_pkg::t_comp clip(input t_wide v, inout logic f);
        if (v > SMAX) begin
            f = 1'b1;
            return v3mu_pkg::t_comp'(SMAX);
        end
        if (v < SMIN) begin
            f = 1'b1;
            return v3mu_pkg::t_comp'(SMIN);
        end
        return v3mu_pkg::t_comp'(v);
    endfunction

    function automatic t_wide trunc_frac(input t_wide v);
        if (v < 0) return -((-v) >>> v3mu_pkg::FB);
        return v >>> v3mu_pkg::FB;
    endfunction

    function automatic v3mu_pkg::t_comp fixed_div(input t_wide n, input t_wide d,
                                                  inout logic f);
        t_wide un;
        t_wide ud;
        t_wide q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (un <<< v3mu_pkg::FB) / ud;
        if ((n < 0) != (d < 0)) q = -q;
        return clip(q, f);
    endfunction

    function automatic t_wide int_sqrt(input t_wide s);
        t_wide r;
        t_wide c;
        r = 0;
        for (int b = 40; b >= 0; b--) begin
            c = r | (t_wide'(1) <<< b);
            if (c * c <= s) r = c;
        end
        return r;
    endfunction

    function automatic t_wide sum_sq(input t_wide x, input t_wide y, input t_wide z);
        return x * x + y * y + z * z;
    endfunction

    function automatic v3mu_pkg::t_rsp vector_result(input v3mu_pkg::t_req q);
        t_wide a[3];
        t_wide b[3];
        t_wide m;
        t_wide sa;
        t_wide sb;
        v3mu_pkg::t_comp r[3];
        v3mu_pkg::t_rsp  o;
        logic  f;
        int    j;
        int    k;
        a[0] = t_wide'(q.a_x); a[1] = t_wide'(q.a_y); a[2] = t_wide'(q.a_z);
        b[0] = t_wide'(q.b_x); b[1] = t_wide'(q.b_y); b[2] = t_wide'(q.b_z);
        r[0] = '0; r[1] = '0; r[2] = '0;
        o = '0;
        f = 1'b0;
        case (q.opcode)
            v3mu_pkg::OP_ADD: for (int i = 0; i < 3; i++) r[i] = clip(a[i] + b[i], f);
            v3mu_pkg::OP_SUB: for (int i = 0; i < 3; i++) r[i] = clip(a[i] - b[i], f);
            v3mu_pkg::OP_MUL: begin
                for (int i = 0; i < 3; i++) r[i] = clip(trunc_frac(a[i] * b[i]), f);
            end
            v3mu_pkg::OP_DIV: begin
                if (b[0] != 0 || b[1] != 0 || b[2] != 0) begin
                    for (int i = 0; i < 3; i++) begin
                        if (b[i] != 0) r[i] = fixed_div(a[i], b[i], f);
                        else if (a[i] > 0) r[i] = clip(SMAX + 1, f);
                        else if (a[i] < 0) r[i] = clip(SMIN - 1, f);
                    end
                end
            end
            v3mu_pkg::OP_DOT: begin
                o.r_scalar = clip(trunc_frac(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), f);
            end
            v3mu_pkg::OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    r[i] = clip(trunc_frac(a[j] * b[k] - b[j] * a[k]), f);
                end
            end
            v3mu_pkg::OP_MAG: o.r_scalar = clip(int_sqrt(sum_sq(a[0], a[1], a[2])), f);
            v3mu_pkg::OP_DIST: o.r_scalar = clip(int_sqrt(sum_sq(a[0] - b[0], a[1] - b[1],
                                                                 a[2] - b[2])), f);
            v3mu_pkg::OP_NORM: begin
                m = int_sqrt(sum_sq(a[0], a[1], a[2]));
                if (m != 0) for (int i = 0; i < 3; i++) r[i] = fixed_div(a[i], m, f);
            end
            v3mu_pkg::OP_SDIV: begin
                if (b[0] > 0) for (int i = 0; i < 3; i++) r[i] = fixed_div(a[i], b[0], f);
            end
            v3mu_pkg::OP_CMP: begin
                sa = sum_sq(a[0], a[1], a[2]);
                sb = sum_sq(b[0], b[1], b[2]);
                o.vec_equal = (a[0] == b[0] && a[1] == b[1] && a[2] == b[2]);
                o.mag_equal = (sa == sb);
                o.mag_less  = (sa < sb);
            end
            default: ;
        endcase
        o.r_x = r[0];
        o.r_y = r[1];
        o.r_z = r[2];
        o.saturated = f;
        return o;
    endfunction

    function automatic v3mu_pkg::t_comp rand_comp();
        case ($urandom_range(0, 5))
            0: return v3mu_pkg::t_comp'(32'h7fffffff - $urandom_range(0, 2));
            1: return v3mu_pkg::t_comp'(32'h80000000 + $urandom_range(0, 2));
            2: return v3mu_pkg::t_comp'($urandom_range(0, 1));
            3: return v3mu_pkg::t_comp'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
            default: return v3mu_pkg::t_comp'($urandom);
        endcase
    endfunction

    function automatic v3mu_pkg::t_req mk(input logic [3:0] op,
                                          input v3mu_pkg::t_comp ax,
                                          input v3mu_pkg::t_comp ay,
                                          input v3mu_pkg::t_comp az,
                                          input v3mu_pkg::t_comp bx,
                                          input v3mu_pkg::t_comp by,
                                          input v3mu_pkg::t_comp bz);
        v3mu_pkg::t_req q;
        q.opcode = op;
        q.a_x = ax; q.a_y = ay; q.a_z = az;
        q.b_x = bx; q.b_y = by; q.b_z = bz;
        return q;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        v3mu_pkg::t_req q;
        v3mu_pkg::t_comp mx;
        v3mu_pkg::t_comp mn;
        v3mu_pkg::t_comp one;
        mx  = v3mu_pkg::t_comp'(SMAX);
        mn  = v3mu_pkg::t_comp'(SMIN);
        one = 32'sh10000;
        // directed corners
        pending_reqs.push_back(mk(v3mu_pkg::OP_ADD, mx, mn, mx, one, -one, mn));
        pending_reqs.push_back(mk(v3mu_pkg::OP_SUB, mn, mx, 0, one, -one, mn));
        pending_reqs.push_back(mk(v3mu_pkg::OP_MUL, mx, mn, mn, mx, mx, mn));
        pending_reqs.push_back(mk(v3mu_pkg::OP_MUL, 3 * one, -one / 2, 7, one, one, -one));
        pending_reqs.push_back(mk(v3mu_pkg::OP_DIV, one, -one, 0, 0, 0, 0));
        pending_reqs.push_back(mk(v3mu_pkg::OP_DIV, one, -one, 0, 0, 0, 0));
        pending_reqs.push_back(mk(v3mu_pkg::OP_DIV, 5 * one, -3 * one, 0, 0, 0, 2 * one));
        pending_reqs.push_back(mk(v3mu_pkg::OP_DIV, mx, mn, one, 1, 1, -one));
        pending_reqs.push_back(mk(v3mu_pkg::OP_DOT, mx, mx, mx, mx, mx, mx));
        pending_reqs.push_back(mk(v3mu_pkg::OP_DOT, mn, mn, mn, mx, mx, mx));
        pending_reqs.push_back(mk(v3mu_pkg::OP_CROSS, one, 0, 0, 0, one, 0));
        pending_reqs.push_back(mk(v3mu_pkg::OP_CROSS, mx, mn, mx, mn, mx, mn));
        pending_reqs.push_back(mk(v3mu_pkg::OP_MAG, mn, mn, mn, 0, 0, 0));
        pending_reqs.push_back(mk(v3mu_pkg::OP_MAG, 3 * one, 4 * one, 0, 0, 0, 0));
        pending_reqs.push_back(mk(v3mu_pkg::OP_DIST, mx, mx, mx, mn, mn, mn));
        pending_reqs.push_back(mk(v3mu_pkg::OP_NORM, 0, 0, 0, one, one, one));
        pending_reqs.push_back(mk(v3mu_pkg::OP_NORM, mn, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk(v3mu_pkg::OP_NORM, 1, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk(v3mu_pkg::OP_SDIV, one, one, one, 0, 0, 0));
        pending_reqs.push_back(mk(v3mu_pkg::OP_SDIV, one, one, one, -one, 0, 0));
        pending_reqs.push_back(mk(v3mu_pkg::OP_SDIV, mx, mn, one, 1, 0, 0));
        pending_reqs.push_back(mk(v3mu_pkg::OP_CMP, one, -one, 2, one, -one, 2));
        pending_reqs.push_back(mk(v3mu_pkg::OP_CMP, one, 0, 0, 0, -one, 0));
        pending_reqs.push_back(mk(v3mu_pkg::OP_CMP, one, 0, 0, mx, 0, 0));
        pending_reqs.push_back(mk(OP_UNUSED, mx, mn, one, one, mx, mn));
        // random requests
        for (int n = 0; n < 1850; n++) begin
            q = mk($urandom_range(0, 19) == 0 ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(0, 10)),
                   rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp(), rand_comp());
            case ($urandom_range(0, 7))
                0: begin
                    q.b_x = q.a_x; q.b_y = q.a_y; q.b_z = q.a_z;
                end
                1: begin
                    q.b_x = q.a_y; q.b_y = -q.a_z; q.b_z = q.a_x;
                end
                2: q.b_y = '0;
                3: if ($urandom_range(0, 1)) q.a_y = '0;
                default: ;
            endcase
            pending_reqs.push_back(q);
        end
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            i_req       <= '0;
            gap_cnt     <= 0;
            req_count   <= 0;
        end else begin
            if (i_req_valid && !o_req_stall) begin
                expected_rsps.push_back(vector_result(i_req));
                req_count <= req_count + 1;
            end
            if (!i_req_valid || !o_req_stall) begin
                if (gap_cnt > 0) begin
                    gap_cnt     <= gap_cnt - 1;
                    i_req_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    i_req_valid <= 1'b1;
                    i_req       <= pending_reqs.pop_front();
                    gap_cnt     <= ((req_count / 300) % 3 == 1) ? 0 : $urandom_range(0, 3);
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // long response hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_cnt  <= 0;
            long_done <= 1'b0;
        end else if (!long_done && rsp_count == 400) begin
            long_cnt  <= 300;
            long_done <= 1'b1;
        end else if (long_cnt > 0) begin
            long_cnt <= long_cnt - 1;
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        v3mu_pkg::t_rsp e;
        if (!i_rst_n) begin
            i_rsp_stall <= 1'b0;
            hold_cnt    = 0;
            rsp_count   <= 0;
        end else begin
            if (o_rsp_valid && !i_rsp_stall) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response, expected none, actual %h", $time, o_rsp);
                    failed = 1'b1;
                end else begin
                    e = expected_rsps.pop_front();
                    if (o_rsp.r_x !== e.r_x || o_rsp.r_y !== e.r_y || o_rsp.r_z !== e.r_z ||
                        o_rsp.r_scalar !== e.r_scalar || o_rsp.vec_equal !== e.vec_equal ||
                        o_rsp.mag_less !== e.mag_less || o_rsp.mag_equal !== e.mag_equal ||
                        o_rsp.saturated !== e.saturated) begin
                        $display("%0t: mismatch, expected %h, actual %h", $time, e, o_rsp);
                        failed = 1'b1;
                    end
                end
                rsp_count <= rsp_count + 1;
                if ((rsp_count / 250) % 3 == 2) hold_cnt = 0;
                else hold_cnt = $urandom_range(0, 3);
            end else if (hold_cnt > 0) begin
                hold_cnt = hold_cnt - 1;
            end
            i_rsp_stall <= (hold_cnt > 0) || (long_cnt > 0);
        end
    end

    initial begin
        failed  = 1'b0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (pending_reqs.size() == 0 && !i_req_valid);
        wait (expected_rsps.size() == 0);
        repeat (200) @(posedge i_clk);
        if (!failed && expected_rsps.size() == 0) begin
            $display("PASS vec3_math_unit_core");
        end else begin
            $display("FAIL vec3_math_unit_core");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL vec3_math_unit_core");
        $finish;
    end

endmodule

@@ files.f @@
src/v3mu_pkg.sv
src/v3mu_lane.sv
src/v3mu_isqrt.sv
src/v3mu_div.sv
src/vec3_math_unit_core.sv
tb/sv/vec3_math_unit_core_tb.sv
